// ----- rtl/glmt_pkg.sv -----
package glmt_pkg;

    localparam int ENTRY_STRIDE = 16;
    localparam int CFG_W        = 16;
    localparam int REG_IDX_W    = 1;
    localparam int PUSH_MAX     = 6;

    localparam logic [REG_IDX_W-1:0] REG_VOCAB_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_UNK_ID      = 1'b1;

    localparam logic [1:0] CMD_ENTRY_BYTE   = 2'd0;
    localparam logic [1:0] CMD_ENTRY_HEADER = 2'd1;
    localparam logic [1:0] CMD_TEXT_BYTE    = 2'd2;
    localparam logic [1:0] CMD_END_TEXT     = 2'd3;

    localparam logic [7:0] MARKER_0   = 8'hE2;
    localparam logic [7:0] MARKER_1   = 8'h96;
    localparam logic [7:0] MARKER_2   = 8'h81;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] entry_index;
        logic [3:0]  byte_position;
        logic [7:0]  data_byte;
        logic [4:0]  entry_length;
        logic [15:0] entry_id;
    } t_in_item;

    typedef struct packed {
        logic [15:0] token_id;
        logic        is_unknown;
        logic        last_of_text;
    } t_out_item;

    typedef struct packed {
        logic [4:0]  len;
        logic [15:0] id;
    } t_hdr;

    typedef logic [ENTRY_STRIDE-1:0][7:0] t_row;

    typedef struct packed {
        logic                     push;
        logic [2:0]               push_cnt;
        logic [PUSH_MAX-1:0][7:0] push_bytes;
        logic                     drop;
        logic [4:0]               drop_len;
    } t_win_ctrl;

endpackage

// ----- rtl/glmt_vocab.sv -----
module glmt_vocab #(
    parameter int VOCAB_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_byte_we,
    input  logic [$clog2(VOCAB_DEPTH)-1:0] i_byte_addr,
    input  logic [3:0]                     i_byte_pos,
    input  logic [7:0]                     i_byte_data,
    input  logic                           i_hdr_we,
    input  logic [$clog2(VOCAB_DEPTH)-1:0] i_hdr_addr,
    input  glmt_pkg::t_hdr                 i_hdr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(VOCAB_DEPTH)-1:0] i_rd_addr,
    output glmt_pkg::t_row                 o_row,
    output glmt_pkg::t_hdr                 o_hdr
);

    glmt_pkg::t_row r_bytes_mem [VOCAB_DEPTH];
    glmt_pkg::t_hdr r_hdr_mem [VOCAB_DEPTH];
    glmt_pkg::t_row r_row;
    glmt_pkg::t_hdr r_hdr;

    always_ff @(posedge i_clk) begin
        if (i_byte_we) begin
            r_bytes_mem[i_byte_addr][i_byte_pos] <= i_byte_data;
        end
        if (i_rd_en) begin
            r_row <= r_bytes_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hdr_we) begin
            r_hdr_mem[i_hdr_addr] <= i_hdr_data;
        end
        if (i_rd_en) begin
            r_hdr <= r_hdr_mem[i_rd_addr];
        end
    end

    assign o_row = r_row;
    assign o_hdr = r_hdr;

endmodule

// ----- rtl/glmt_window.sv -----
module glmt_window #(
    parameter int LOOKAHEAD_LEN = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  glmt_pkg::t_win_ctrl               i_ctrl,
    input  glmt_pkg::t_row                    i_row,
    input  logic [4:0]                        i_len,
    output logic [$clog2(LOOKAHEAD_LEN+6)-1:0] o_fill,
    output logic                              o_match
);

    localparam int WIN = LOOKAHEAD_LEN + 5;
    localparam int FW  = $clog2(WIN + 1);

    logic [7:0]    r_win [WIN];
    logic [7:0]    n_win [WIN];
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (i_ctrl.push) begin
            for (int j = 0; j < WIN; j++) begin
                if (j >= int'(r_fill) && j < int'(r_fill) + int'(i_ctrl.push_cnt)) begin
                    n_win[j] = i_ctrl.push_bytes[3'(j - int'(r_fill))];
                end
            end
            if (int'(r_fill) + int'(i_ctrl.push_cnt) > WIN) begin
                n_fill = FW'(WIN);
            end else begin
                n_fill = r_fill + FW'(i_ctrl.push_cnt);
            end
        end else if (i_ctrl.drop) begin
            for (int j = 0; j < WIN; j++) begin
                if (j + int'(i_ctrl.drop_len) < WIN) begin
                    n_win[j] = r_win[j + int'(i_ctrl.drop_len)];
                end else begin
                    n_win[j] = 8'h00;
                end
            end
            n_fill = r_fill - FW'(i_ctrl.drop_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int j = 0; j < WIN; j++) begin
                r_win[j] <= 8'h00;
            end
        end else begin
            r_fill <= n_fill;
            r_win  <= n_win;
        end
    end

    // prefix compare over the entry length
    always_comb begin
        o_match = 1'b1;
        for (int b = 0; b < glmt_pkg::ENTRY_STRIDE; b++) begin
            if (b < WIN) begin
                if (b < int'(i_len) && r_win[b] != i_row[b]) begin
                    o_match = 1'b0;
                end
            end
        end
    end

    assign o_fill = r_fill;

endmodule

// ----- rtl/greedy_longest_match_tokenizer_top.sv -----
// Greedy longest-match tokenizer. Table commands (entry byte, entry header) are taken while busy
// stays low. A text byte or end-of-text item holds busy high while it resolves tokens: each
// emitted token is found by a walk over the entry memory at one entry per cycle through its
// single read port, and after its last token the item returns through the check state to idle.
// After reset the header memory is cleared one entry per cycle, with busy high until every
// entry is cleared; configuration writes are taken during that time. Results appear on o_result
// for exactly one cycle with o_result_valid and cannot be held off.
module greedy_longest_match_tokenizer_top #(
    parameter int VOCAB_DEPTH   = 4096,
    parameter int LOOKAHEAD_LEN = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  glmt_pkg::t_in_item               i_item,
    output logic                             o_result_valid,
    output glmt_pkg::t_out_item              o_result,
    input  logic                             i_cfg_we,
    input  logic [glmt_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [glmt_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int AW  = $clog2(VOCAB_DEPTH);
    localparam int CW  = $clog2(VOCAB_DEPTH + 1);
    localparam int WIN = LOOKAHEAD_LEN + 5;
    localparam int FW  = $clog2(WIN + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]          r_state;
    logic [CW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [4:0]          r_best_len;
    logic [15:0]         r_best_id;
    logic                r_at_end;
    logic                r_started;
    logic [12:0]         r_vocab_count;
    logic [15:0]         r_unk_id;
    logic                r_out_valid;
    glmt_pkg::t_out_item r_out;

    logic                accept;
    logic                idx_ok;
    logic [CW-1:0]       limit;
    logic                issue;
    logic                hit;
    logic                need;
    logic                emit_unk;
    logic [4:0]          emit_drop;
    logic [FW-1:0]       fill_after;
    logic [2:0]          push_cnt;
    logic [glmt_pkg::PUSH_MAX-1:0][7:0] push_bytes;

    glmt_pkg::t_win_ctrl win_ctrl;
    glmt_pkg::t_row      w_row;
    glmt_pkg::t_hdr      w_hdr;
    glmt_pkg::t_hdr      hdr_wdata;
    logic [FW-1:0]       w_fill;
    logic                w_match;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign idx_ok = 32'(i_item.entry_index) < 32'(VOCAB_DEPTH);
    assign limit  = (32'(r_vocab_count) > 32'(VOCAB_DEPTH)) ? CW'(VOCAB_DEPTH)
                                                            : CW'(r_vocab_count);
    assign issue  = (r_state == ST_SCAN) && (r_addr < limit);

    // marker at text start, space becomes marker
    always_comb begin
        push_cnt   = 3'd0;
        push_bytes = '0;
        if (!r_started) begin
            push_bytes[0] = glmt_pkg::MARKER_0;
            push_bytes[1] = glmt_pkg::MARKER_1;
            push_bytes[2] = glmt_pkg::MARKER_2;
            push_cnt      = 3'd3;
        end
        if (i_item.command == glmt_pkg::CMD_TEXT_BYTE) begin
            if (i_item.data_byte == glmt_pkg::SPACE_BYTE) begin
                push_bytes[push_cnt]        = glmt_pkg::MARKER_0;
                push_bytes[push_cnt + 3'd1] = glmt_pkg::MARKER_1;
                push_bytes[push_cnt + 3'd2] = glmt_pkg::MARKER_2;
                push_cnt                    = push_cnt + 3'd3;
            end else begin
                push_bytes[push_cnt] = i_item.data_byte;
                push_cnt             = push_cnt + 3'd1;
            end
        end
    end

    assign emit_unk   = (r_best_len == 5'd0);
    assign emit_drop  = emit_unk ? 5'd1 : r_best_len;
    assign fill_after = w_fill - FW'(emit_drop);
    assign need       = r_at_end ? (w_fill != '0) : (int'(w_fill) >= LOOKAHEAD_LEN);

    always_comb begin
        win_ctrl.push       = accept && (i_item.command == glmt_pkg::CMD_TEXT_BYTE ||
                                         i_item.command == glmt_pkg::CMD_END_TEXT);
        win_ctrl.push_cnt   = push_cnt;
        win_ctrl.push_bytes = push_bytes;
        win_ctrl.drop       = (r_state == ST_EMIT);
        win_ctrl.drop_len   = emit_drop;
    end

    assign hit = r_rd_vld && (w_hdr.len != 5'd0)
              && (int'(w_hdr.len) <= LOOKAHEAD_LEN)
              && (int'(w_hdr.len) <= glmt_pkg::ENTRY_STRIDE)
              && (int'(w_hdr.len) <= int'(w_fill))
              && (w_hdr.len > r_best_len) && w_match;

    assign hdr_wdata.len = (r_state == ST_CLEAR) ? 5'd0 : i_item.entry_length;
    assign hdr_wdata.id  = (r_state == ST_CLEAR) ? 16'd0 : i_item.entry_id;

    glmt_vocab #(
        .VOCAB_DEPTH(VOCAB_DEPTH)
    ) u_vocab (
        .i_clk       (i_clk),
        .i_byte_we   (accept && i_item.command == glmt_pkg::CMD_ENTRY_BYTE && idx_ok),
        .i_byte_addr (AW'(i_item.entry_index)),
        .i_byte_pos  (i_item.byte_position),
        .i_byte_data (i_item.data_byte),
        .i_hdr_we    ((r_state == ST_CLEAR) ||
                      (accept && i_item.command == glmt_pkg::CMD_ENTRY_HEADER && idx_ok)),
        .i_hdr_addr  ((r_state == ST_CLEAR) ? r_addr[AW-1:0] : AW'(i_item.entry_index)),
        .i_hdr_data  (hdr_wdata),
        .i_rd_en     (issue),
        .i_rd_addr   (r_addr[AW-1:0]),
        .o_row       (w_row),
        .o_hdr       (w_hdr)
    );

    glmt_window #(
        .LOOKAHEAD_LEN(LOOKAHEAD_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (win_ctrl),
        .i_row   (w_row),
        .i_len   (w_hdr.len),
        .o_fill  (w_fill),
        .o_match (w_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_addr        <= '0;
            r_rd_vld      <= 1'b0;
            r_best_len    <= 5'd0;
            r_at_end      <= 1'b0;
            r_started     <= 1'b0;
            r_vocab_count <= 13'd0;
            r_unk_id      <= 16'd1;
            r_out_valid   <= 1'b0;
        end else begin
            r_rd_vld    <= issue;
            r_out_valid <= (r_state == ST_EMIT);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    glmt_pkg::REG_VOCAB_COUNT: r_vocab_count <= i_cfg_data[12:0];
                    glmt_pkg::REG_UNK_ID:      r_unk_id      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + CW'(1);
                    if (r_addr == CW'(VOCAB_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (win_ctrl.push) begin
                        r_at_end  <= (i_item.command == glmt_pkg::CMD_END_TEXT);
                        r_started <= (i_item.command == glmt_pkg::CMD_TEXT_BYTE);
                        r_state   <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (need) begin
                        r_addr     <= '0;
                        r_best_len <= 5'd0;
                        r_state    <= ST_SCAN;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        r_addr <= r_addr + CW'(1);
                    end
                    if (hit) begin
                        r_best_len <= w_hdr.len;
                        r_best_id  <= w_hdr.id;
                    end
                    if (!issue && !r_rd_vld) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    r_state <= ST_CHECK;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT) begin
            r_out.token_id     <= emit_unk ? r_unk_id : r_best_id;
            r_out.is_unknown   <= emit_unk;
            r_out.last_of_text <= r_at_end && (fill_after == '0);
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) == ST_EMIT)
        else $error("result strobe without emit");

    a_last_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_of_text) |=> !busy)
        else $error("block still busy after last item of text");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_fill) <= WIN)
        else $error("window fill beyond depth");

    a_idle_window_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> int'(w_fill) < LOOKAHEAD_LEN)
        else $error("idle with full window");

endmodule

// ----- tb/tokenizer_checker.sv -----
module tokenizer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  glmt_pkg::t_in_item             i_item,
    input  logic                           i_result_valid,
    input  glmt_pkg::t_out_item            i_result,
    input  logic                           i_cfg_we,
    input  logic [glmt_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [glmt_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_cnt,
    output int                             o_pending
);

    localparam int DEPTH     = 4096;
    localparam int TOKEN_MAX = 16;
    localparam int WIN       = TOKEN_MAX + 5;

    logic [7:0]          vocab_bytes [DEPTH][glmt_pkg::ENTRY_STRIDE];
    logic [4:0]          vocab_len [DEPTH];
    logic [15:0]         vocab_id [DEPTH];
    logic [7:0]          window [WIN];
    int                  fill;
    bit                  in_text;
    logic [12:0]         search_count;
    logic [15:0]         unknown_id;
    glmt_pkg::t_out_item token_queue [$];

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    function automatic void push_window(logic [7:0] b);
        if (fill < WIN) begin
            window[fill] = b;
            fill++;
        end
    endfunction

    function automatic void push_marker();
        push_window(glmt_pkg::MARKER_0);
        push_window(glmt_pkg::MARKER_1);
        push_window(glmt_pkg::MARKER_2);
    endfunction

    function automatic void resolve_token(bit at_end);
        int                  limit;
        int                  best;
        int                  best_len;
        int                  len;
        int                  drop;
        bit                  hit;
        glmt_pkg::t_out_item tok;
        limit    = (int'(search_count) > DEPTH) ? DEPTH : int'(search_count);
        best     = 0;
        best_len = 0;
        for (int e = 0; e < limit; e++) begin
            len = int'(vocab_len[e]);
            if (len == 0 || len > TOKEN_MAX || len > glmt_pkg::ENTRY_STRIDE || len > fill
                    || len <= best_len)
                continue;
            hit = 1'b1;
            for (int j = 0; j < len; j++)
                if (window[j] != vocab_bytes[e][j])
                    hit = 1'b0;
            if (hit) begin
                best     = e;
                best_len = len;
            end
        end
        if (best_len > 0) begin
            tok.token_id   = vocab_id[best];
            tok.is_unknown = 1'b0;
            drop           = best_len;
        end else begin
            tok.token_id   = unknown_id;
            tok.is_unknown = 1'b1;
            drop           = 1;
        end
        if (drop > fill)
            drop = fill;
        for (int j = 0; j < WIN; j++)
            window[j] = (j + drop < WIN) ? window[j + drop] : 8'h00;
        fill = fill - drop;
        for (int j = fill; j < WIN; j++)
            window[j] = 8'h00;
        tok.last_of_text = at_end && fill == 0;
        token_queue.push_back(tok);
    endfunction

    function automatic void predict(glmt_pkg::t_in_item it);
        case (it.command)
            glmt_pkg::CMD_ENTRY_BYTE: begin
                vocab_bytes[it.entry_index][it.byte_position] = it.data_byte;
            end
            glmt_pkg::CMD_ENTRY_HEADER: begin
                vocab_len[it.entry_index] = it.entry_length;
                vocab_id[it.entry_index]  = it.entry_id;
            end
            default: begin
                if (!in_text) begin
                    push_marker();
                    in_text = 1'b1;
                end
                if (it.command == glmt_pkg::CMD_TEXT_BYTE) begin
                    if (it.data_byte == glmt_pkg::SPACE_BYTE)
                        push_marker();
                    else
                        push_window(it.data_byte);
                    while (fill >= TOKEN_MAX)
                        resolve_token(1'b0);
                end else begin
                    while (fill > 0)
                        resolve_token(1'b1);
                    in_text = 1'b0;
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        glmt_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int e = 0; e < DEPTH; e++)
                vocab_len[e] = '0;
            for (int j = 0; j < WIN; j++)
                window[j] = 8'h00;
            fill         = 0;
            in_text      = 1'b0;
            search_count = '0;
            unknown_id   = 16'd1;
            token_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    glmt_pkg::REG_VOCAB_COUNT: search_count = i_cfg_data[12:0];
                    glmt_pkg::REG_UNK_ID:      unknown_id   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                predict(i_item);
            if (i_result_valid) begin
                if (token_queue.size() == 0) begin
                    $error("unexpected result token_id %h", i_result.token_id);
                    o_fail_cnt++;
                end else begin
                    want = token_queue.pop_front();
                    if (i_result.token_id !== want.token_id) begin
                        $error("token_id expected %h got %h", want.token_id,
                               i_result.token_id);
                        o_fail_cnt++;
                    end
                    if (i_result.is_unknown !== want.is_unknown) begin
                        $error("is_unknown expected %b got %b", want.is_unknown,
                               i_result.is_unknown);
                        o_fail_cnt++;
                    end
                    if (i_result.last_of_text !== want.last_of_text) begin
                        $error("last_of_text expected %b got %b", want.last_of_text,
                               i_result.last_of_text);
                        o_fail_cnt++;
                    end
                end
            end
        end
        o_pending = token_queue.size();
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int IDLE_LIMIT = 40000;
    localparam int IN_W       = $bits(glmt_pkg::t_in_item);
    localparam int CFG_BITS   = glmt_pkg::CFG_W;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    glmt_pkg::t_in_item             item_bus;
    logic                           result_valid;
    glmt_pkg::t_out_item            result;
    logic                           cfg_we;
    logic [glmt_pkg::REG_IDX_W-1:0] cfg_index;
    logic [glmt_pkg::CFG_W-1:0]     cfg_data;
    int                             fail_cnt;
    int                             pending;

    logic [7:0] entry_text [4096][16];
    int         entry_size [4096];
    int         usable [$];
    int         burst_left;
    int         idle_cycles;

    greedy_longest_match_tokenizer_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (item_bus),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    tokenizer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item_bus),
        .i_result_valid (result_valid),
        .i_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_cnt     (fail_cnt),
        .o_pending      (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("greedy_longest_match_tokenizer_top: mismatch");
            $finish;
        end
    end

    function automatic glmt_pkg::t_in_item noise_fields(logic [1:0] cmd);
        glmt_pkg::t_in_item it;
        it               = IN_W'({$urandom, $urandom});
        it.command       = cmd;
        return it;
    endfunction

    task automatic send(glmt_pkg::t_in_item it);
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = 1 + $urandom_range(0, ($urandom_range(0, 3) == 0) ? 40 : 8);
        end
        item_bus <= it;
        start    <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic write_reg(logic [glmt_pkg::REG_IDX_W-1:0] idx,
                             logic [glmt_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0 || busy);
        repeat (8) @(negedge clk);
    endtask

    // bytes come from entry_text, written before the header
    task automatic load_entry(int idx, int len, logic [15:0] id);
        glmt_pkg::t_in_item it;
        if (len <= 16) begin
            for (int p = 0; p < len; p++) begin
                it               = noise_fields(glmt_pkg::CMD_ENTRY_BYTE);
                it.entry_index   = 12'(idx);
                it.byte_position = 4'(p);
                it.data_byte     = entry_text[idx][p];
                send(it);
            end
        end
        it              = noise_fields(glmt_pkg::CMD_ENTRY_HEADER);
        it.entry_index  = 12'(idx);
        it.entry_length = 5'(len);
        it.entry_id     = id;
        send(it);
        entry_size[idx] = len;
        if (len >= 1 && len <= 16)
            usable.push_back(idx);
    endtask

    task automatic text_byte(logic [7:0] b);
        glmt_pkg::t_in_item it;
        it           = noise_fields(glmt_pkg::CMD_TEXT_BYTE);
        it.data_byte = b;
        send(it);
    endtask

    task automatic end_text();
        send(noise_fields(glmt_pkg::CMD_END_TEXT));
    endtask

    task automatic random_item(int idx_max, ref int sent);
        int                 r;
        int                 idx;
        int                 len;
        int                 src;
        glmt_pkg::t_in_item it;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, idx_max);
            r   = $urandom_range(0, 9);
            len = (r == 0) ? 0 : (r == 1) ? $urandom_range(17, 31) : $urandom_range(1, 16);
            src = (usable.size() > 0 && $urandom_range(0, 2) == 0)
                ? usable[$urandom_range(0, usable.size() - 1)] : -1;
            for (int p = 0; p < 16; p++) begin
                if (src >= 0 && p < entry_size[src])
                    entry_text[idx][p] = entry_text[src][p];
                else
                    case ($urandom_range(0, 5))
                        0: entry_text[idx][p] = glmt_pkg::MARKER_0;
                        1: entry_text[idx][p] = glmt_pkg::MARKER_1;
                        2: entry_text[idx][p] = glmt_pkg::MARKER_2;
                        3: entry_text[idx][p] = 8'($urandom_range(0, 255));
                        default: entry_text[idx][p] = 8'h61 + 8'($urandom_range(0, 2));
                    endcase
            end
            load_entry(idx, len, 16'($urandom));
            sent += (len <= 16) ? len + 1 : 1;
        end else if (r < 16) begin
            it = noise_fields(glmt_pkg::CMD_ENTRY_BYTE);
            if ($urandom_range(0, 1) == 0)
                it.entry_index = 12'($urandom_range(0, idx_max));
            entry_text[it.entry_index][it.byte_position] = it.data_byte;
            send(it);
            sent++;
        end else if (r < 24) begin
            end_text();
            sent++;
        end else if (r < 72 && usable.size() > 0) begin
            idx = usable[$urandom_range(0, usable.size() - 1)];
            for (int p = 0; p < entry_size[idx]; p++)
                text_byte(entry_text[idx][p]);
            sent += entry_size[idx];
        end else if (r < 84) begin
            text_byte(glmt_pkg::SPACE_BYTE);
            sent++;
        end else begin
            text_byte(8'($urandom_range(0, 255)));
            sent++;
        end
    endtask

    initial begin
        int           sent;
        int           counts [7];
        int           budget [7];
        logic [15:0]  unk_ids [7];
        rst_n       = 1'b0;
        start       = 1'b0;
        item_bus    = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        burst_left  = 0;
        idle_cycles = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty text against an empty table
        write_reg(glmt_pkg::REG_VOCAB_COUNT, 16'd0);
        write_reg(glmt_pkg::REG_UNK_ID, 16'hFFFF);
        end_text();
        wait_idle();

        entry_text[0][0] = glmt_pkg::MARKER_0;
        entry_text[0][1] = glmt_pkg::MARKER_1;
        entry_text[0][2] = glmt_pkg::MARKER_2;
        load_entry(0, 3, 16'h0100);
        entry_text[1][0] = 8'h61;
        load_entry(1, 1, 16'h0001);
        entry_text[2][0] = 8'h61;
        entry_text[2][1] = 8'h62;
        load_entry(2, 2, 16'h0002);
        entry_text[3][0] = 8'h61;
        entry_text[3][1] = 8'h62;
        load_entry(3, 2, 16'h0003);
        load_entry(4, 17, 16'h0004);
        load_entry(5, 0, 16'h0005);
        load_entry(7, 31, 16'h0007);
        entry_text[4095][0] = 8'hFF;
        load_entry(4095, 1, 16'hFFFF);
        wait_idle();
        write_reg(glmt_pkg::REG_VOCAB_COUNT, 16'd16);
        write_reg(glmt_pkg::REG_UNK_ID, 16'h0000);
        text_byte(8'h61);
        text_byte(8'h62);
        text_byte(glmt_pkg::SPACE_BYTE);
        text_byte(8'h63);
        text_byte(8'hFF);
        end_text();
        wait_idle();

        counts  = '{16, 64, 0, 3, 4096, 8191, 40};
        budget  = '{25, 25, 6, 8, 8, 6, 12};
        unk_ids = '{16'h1234, 16'h0000, 16'hFFFF, 16'h0001, 16'h5A5A, 16'hA5A5, 16'h00FF};
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(glmt_pkg::REG_VOCAB_COUNT, CFG_BITS'(counts[ph]));
            write_reg(glmt_pkg::REG_UNK_ID,
                      ($urandom_range(0, 1) == 0) ? unk_ids[ph] : CFG_BITS'($urandom));
            sent = 0;
            while (sent < budget[ph])
                random_item((counts[ph] > 0 && counts[ph] < 64) ? counts[ph] - 1 : 63, sent);
            end_text();
            wait_idle();
        end

        repeat (20) @(negedge clk);
        if (fail_cnt == 0 && pending == 0)
            $display("greedy_longest_match_tokenizer_top: match");
        else
            $display("greedy_longest_match_tokenizer_top: mismatch");
        $finish;
    end

endmodule
